// File: sv/tcpg_pkg.sv
// shared types, character codes and status codes of the text command pulse generator
package tcpg_pkg;

	// command layout
	localparam int CMD_LEN   = 12;
	localparam int POS_W     = 4;
	localparam int COUNT_W   = 10;
	localparam int TICKS_W   = 24;
	localparam int PHASE_W   = COUNT_W + TICKS_W;
	localparam int CFG_IDX_W = 2;

	// ascii codes
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_QUERY = 8'h3F;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_U     = 8'h75;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_SEC  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_MSEC = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_USEC = 2'd2;

	typedef enum logic [1:0] {
		ST_NONE   = 2'd0,
		ST_ACCEPT = 2'd1,
		ST_ERROR  = 2'd2,
		ST_ABORT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		UNIT_SEC  = 2'd0,
		UNIT_MSEC = 2'd1,
		UNIT_USEC = 2'd2
	} unit_t;

	// outcome of one byte, from the parser to the pulse generator
	typedef struct packed {
		status_t              status;
		logic                 load;
		logic                 stop;
		logic [COUNT_W-1:0]   high_count;
		logic [COUNT_W-1:0]   low_count;
		unit_t                high_unit;
		unit_t                low_unit;
	} cmd_result_t;

endpackage

// File: sv/tcpg_cmd_parse.sv
// command byte collection, format check and decode of phase counts and units
module tcpg_cmd_parse import tcpg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic        command,
	input  logic [7:0]  rx_byte,
	output cmd_result_t result
);

	logic [7:0]       char_q [CMD_LEN];
	logic [POS_W-1:0] wpos_q;
	logic [POS_W-1:0] wpos_next;
	logic             store_en;
	logic             format_ok;
	logic             hu_ok;
	logic             lu_ok;
	logic [1:0]       hu_bits;
	logic [1:0]       lu_bits;
	unit_t            hu;
	unit_t            lu;

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	// returns {known, unit}
	function automatic logic [2:0] decode_unit(input logic [7:0] c);
		logic [2:0] r;
		case (c)
			CH_SPACE: r = {1'b1, UNIT_SEC};
			CH_M:     r = {1'b1, UNIT_MSEC};
			CH_U:     r = {1'b1, UNIT_USEC};
			default:  r = {1'b0, UNIT_SEC};
		endcase
		return r;
	endfunction

	// three digit field, low nibble of a digit character is its value
	function automatic logic [COUNT_W-1:0] three_digits(input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] c);
		logic [COUNT_W-1:0] da;
		logic [COUNT_W-1:0] db;
		logic [COUNT_W-1:0] dc;
		da = {6'b0, a[3:0]};
		db = {6'b0, b[3:0]};
		dc = {6'b0, c[3:0]};
		return da * 10'd100 + db * 10'd10 + dc;
	endfunction

	// format and unit checks on the stored command
	always_comb begin
		format_ok = is_digit(char_q[0]) && is_digit(char_q[1]) && is_digit(char_q[2])
			&& is_digit(char_q[5]) && is_digit(char_q[6]) && is_digit(char_q[7])
			&& is_digit(char_q[10]) && is_digit(char_q[11])
			&& (char_q[4] == CH_S) && (char_q[9] == CH_S);
		{hu_ok, hu_bits} = decode_unit(char_q[3]);
		{lu_ok, lu_bits} = decode_unit(char_q[8]);
		hu = unit_t'(hu_bits);
		lu = unit_t'(lu_bits);
	end

	// byte handling
	always_comb begin
		result            = '0;
		result.status     = ST_NONE;
		result.high_count = three_digits(char_q[0], char_q[1], char_q[2]);
		result.low_count  = three_digits(char_q[5], char_q[6], char_q[7]);
		result.high_unit  = hu;
		result.low_unit   = lu;
		wpos_next         = wpos_q;
		store_en          = 1'b0;
		if (fire && !command) begin
			if (rx_byte == CH_CR) begin
				result.status = ST_NONE;
			end else if (rx_byte == CH_G) begin
				wpos_next = '0;
				if (wpos_q != POS_W'(CMD_LEN)) begin
					result.status = ST_ERROR;
				end else if (!format_ok) begin
					result.status = ST_ERROR;
				end else if (!hu_ok || !lu_ok) begin
					result.status = ST_ERROR;
					result.stop   = 1'b1;
				end else begin
					result.status = ST_ACCEPT;
					result.load   = 1'b1;
				end
			end else if (rx_byte == CH_QUERY) begin
				result.status = ST_ABORT;
				wpos_next     = '0;
			end else if (wpos_q >= POS_W'(CMD_LEN)) begin
				result.status = ST_ERROR;
				wpos_next     = '0;
			end else begin
				store_en  = 1'b1;
				wpos_next = wpos_q + 1'b1;
			end
		end
	end

	// write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
		end else begin
			wpos_q <= wpos_next;
		end
	end

	// character store
	always_ff @(posedge clk) begin
		if (store_en) begin
			char_q[wpos_q] <= rx_byte;
		end
	end

endmodule

// File: sv/tcpg_pulse.sv
// phase counts, units and the phase down counter that drive the two pins
module tcpg_pulse import tcpg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic               command,
	input  cmd_result_t        result,
	input  logic [TICKS_W-1:0] ticks_sec,
	input  logic [TICKS_W-1:0] ticks_msec,
	input  logic [TICKS_W-1:0] ticks_usec,
	output logic               drive_next,
	output logic               drive_n_next
);

	logic [COUNT_W-1:0] high_count_q;
	logic [COUNT_W-1:0] low_count_q;
	unit_t              high_unit_q;
	unit_t              low_unit_q;
	logic               running_q;
	logic               in_high_q;
	logic [PHASE_W-1:0] remain_q;

	logic [COUNT_W-1:0] cnt_h;
	logic [COUNT_W-1:0] cnt_l;
	unit_t              unit_h;
	unit_t              unit_l;
	logic [TICKS_W-1:0] ut_h;
	logic [TICKS_W-1:0] ut_l;
	logic [PHASE_W-1:0] len_h;
	logic [PHASE_W-1:0] len_l;
	logic               running_d;
	logic               in_high_d;
	logic [PHASE_W-1:0] remain_d;
	logic               want_high;
	logic               do_load;

	function automatic logic [TICKS_W-1:0] unit_ticks(input unit_t u,
			input logic [TICKS_W-1:0] s, input logic [TICKS_W-1:0] ms,
			input logic [TICKS_W-1:0] us);
		logic [TICKS_W-1:0] r;
		case (u)
			UNIT_SEC:  r = s;
			UNIT_MSEC: r = ms;
			UNIT_USEC: r = us;
			default:   r = '0;
		endcase
		return r;
	endfunction

	// phase lengths from the counts in force after this item
	always_comb begin
		cnt_h  = result.load ? result.high_count : high_count_q;
		cnt_l  = result.load ? result.low_count  : low_count_q;
		unit_h = result.load ? result.high_unit  : high_unit_q;
		unit_l = result.load ? result.low_unit   : low_unit_q;
		ut_h   = unit_ticks(unit_h, ticks_sec, ticks_msec, ticks_usec);
		ut_l   = unit_ticks(unit_l, ticks_sec, ticks_msec, ticks_usec);
		len_h  = {{TICKS_W{1'b0}}, cnt_h} * {{COUNT_W{1'b0}}, ut_h};
		len_l  = {{TICKS_W{1'b0}}, cnt_l} * {{COUNT_W{1'b0}}, ut_l};
	end

	// next phase state
	always_comb begin
		running_d = running_q;
		in_high_d = in_high_q;
		remain_d  = remain_q;
		do_load   = 1'b0;
		want_high = 1'b1;
		if (fire) begin
			if (command) begin
				if (running_q) begin
					if (remain_q > PHASE_W'(1)) begin
						remain_d = remain_q - 1'b1;
					end else begin
						do_load   = 1'b1;
						want_high = !in_high_q;
					end
				end
			end else if (result.load) begin
				running_d = 1'b1;
				do_load   = 1'b1;
				want_high = 1'b1;
			end else if (result.stop) begin
				running_d = 1'b0;
				in_high_d = 1'b0;
				remain_d  = '0;
			end
		end
		// a zero-length phase is skipped in favor of the other one
		if (do_load) begin
			if (want_high && len_h != '0) begin
				in_high_d = 1'b1;
				remain_d  = len_h;
			end else if (!want_high && len_l != '0) begin
				in_high_d = 1'b0;
				remain_d  = len_l;
			end else if (len_h != '0) begin
				in_high_d = 1'b1;
				remain_d  = len_h;
			end else if (len_l != '0) begin
				in_high_d = 1'b0;
				remain_d  = len_l;
			end else begin
				in_high_d = 1'b0;
				remain_d  = '0;
			end
		end
		drive_next   = running_d && in_high_d;
		drive_n_next = running_d && !in_high_d;
	end

	// phase state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_count_q <= '0;
			low_count_q  <= '0;
			high_unit_q  <= UNIT_SEC;
			low_unit_q   <= UNIT_SEC;
			running_q    <= 1'b0;
			in_high_q    <= 1'b0;
			remain_q     <= '0;
		end else begin
			if (fire && result.load) begin
				high_count_q <= result.high_count;
				low_count_q  <= result.low_count;
				high_unit_q  <= result.high_unit;
				low_unit_q   <= result.low_unit;
			end
			running_q <= running_d;
			in_high_q <= in_high_d;
			remain_q  <= remain_d;
		end
	end

endmodule

// File: sv/text_command_pulse_generator_core.sv
// top level of the text command pulse generator: input stage, result register, config
//
// channel | direction | handshake             | payload
// in      | in        | in_valid / in_stall   | command, rx_byte
// out     | out       | out_valid / out_stall | drive_out, drive_out_n, status
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle sustained while out is not stalled; an item goes from its transfer
// into the input register, then into the result register and so onto the outputs;
// all checks and the phase multiply sit between the two registers
// reset clears the pipeline, the write position, the phase state and loads the tick defaults
// in_stall is high only while both the input and result registers hold items and out is stalled
// cfg_ready is always high; a write to an unused index is dropped
module text_command_pulse_generator_core import tcpg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 drive_out,
	output logic                 drive_out_n,
	output logic [1:0]           status,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICKS_W-1:0]   cfg_data
);

	logic               valid_s1;
	logic               command_s1;
	logic [7:0]         rx_byte_s1;
	logic               advance;
	logic               in_xfer;
	logic [TICKS_W-1:0] ticks_sec_q;
	logic [TICKS_W-1:0] ticks_msec_q;
	logic [TICKS_W-1:0] ticks_usec_q;
	cmd_result_t        result;
	logic               drive_next;
	logic               drive_n_next;

	// pipeline flow
	assign advance  = valid_s1 && !(out_valid && out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_sec_q  <= TICKS_W'(1000000);
			ticks_msec_q <= TICKS_W'(1000);
			ticks_usec_q <= TICKS_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TICKS_SEC:  ticks_sec_q  <= cfg_data;
				CFG_TICKS_MSEC: ticks_msec_q <= cfg_data;
				CFG_TICKS_USEC: ticks_usec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			command_s1 <= command;
			rx_byte_s1 <= rx_byte;
		end
	end

	tcpg_cmd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (advance),
		.command (command_s1),
		.rx_byte (rx_byte_s1),
		.result  (result)
	);

	tcpg_pulse u_pulse (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.command      (command_s1),
		.result       (result),
		.ticks_sec    (ticks_sec_q),
		.ticks_msec   (ticks_msec_q),
		.ticks_usec   (ticks_usec_q),
		.drive_next   (drive_next),
		.drive_n_next (drive_n_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_out   <= drive_next;
			drive_out_n <= drive_n_next;
			status      <= command_s1 ? ST_NONE : result.status;
		end
	end

endmodule

// File: sv/tcpg_checker.sv
// port level checks of the text command pulse generator and their bind
module tcpg_checker import tcpg_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drive_out,
	input logic       drive_out_n,
	input logic [1:0] status
);

	// the two pins are never high together
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_out && drive_out_n))
		else $error("both drive pins high");

	// an accepted command always starts the pulse on one of the pins
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_ACCEPT) |-> (drive_out || drive_out_n))
		else $error("accepted command with both pins low");

	// the input side only stalls while the output side holds a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || !out_stall) |-> !in_stall)
		else $error("input stalled without output backpressure");

	// a stalled result stays until its transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable({drive_out, drive_out_n, status})))
		else $error("stalled result changed");

endmodule

bind text_command_pulse_generator_core tcpg_checker u_tcpg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.drive_out   (drive_out),
	.drive_out_n (drive_out_n),
	.status      (status)
);

// File: tb/tcpg_tb_pkg.sv
// scoreboard class holding the pulse generator predictor and the expected pin states
package tcpg_tb_pkg;
	import tcpg_pkg::*;

	// pins and status expected after one item
	typedef struct packed {
		logic    drive;
		logic    drive_n;
		status_t status;
	} pin_state_t;

	class pulse_scoreboard;
		logic [TICKS_W-1:0] ticks_sec;
		logic [TICKS_W-1:0] ticks_msec;
		logic [TICKS_W-1:0] ticks_usec;
		logic [7:0]         chars [CMD_LEN];
		int unsigned        wr_pos;
		logic [COUNT_W-1:0] high_count;
		logic [COUNT_W-1:0] low_count;
		unit_t              high_unit;
		unit_t              low_unit;
		bit                 running;
		bit                 in_high;
		logic [PHASE_W-1:0] remaining;
		pin_state_t         expected_pins [$];
		int                 fails;
		int                 items;
		int                 accepted;
		int                 errors;
		int                 aborts;
		int                 toggles;
		bit                 last_drive;

		function new();
			ticks_sec  = 24'd1000000;
			ticks_msec = 24'd1000;
			ticks_usec = 24'd1;
			foreach (chars[i]) chars[i] = 8'h00;
			wr_pos     = 0;
			high_count = '0;
			low_count  = '0;
			high_unit  = UNIT_SEC;
			low_unit   = UNIT_SEC;
			running    = 1'b0;
			in_high    = 1'b0;
			remaining  = '0;
			fails      = 0;
			items      = 0;
			accepted   = 0;
			errors     = 0;
			aborts     = 0;
			toggles    = 0;
			last_drive = 1'b0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICKS_W-1:0] value);
			case (idx)
				CFG_TICKS_SEC:  ticks_sec  = value;
				CFG_TICKS_MSEC: ticks_msec = value;
				CFG_TICKS_USEC: ticks_usec = value;
				default: ;
			endcase
		endfunction

		// phase length in ticks from the current register values
		function logic [PHASE_W-1:0] phase_ticks(logic [COUNT_W-1:0] count, unit_t unit);
			logic [PHASE_W-1:0] per_unit;
			case (unit)
				UNIT_SEC:  per_unit = PHASE_W'(ticks_sec);
				UNIT_MSEC: per_unit = PHASE_W'(ticks_msec);
				UNIT_USEC: per_unit = PHASE_W'(ticks_usec);
				default:   per_unit = '0;
			endcase
			return PHASE_W'(count) * per_unit;
		endfunction

		// pick the next phase, skipping zero-length ones
		function void load_phase(bit want_high);
			logic [PHASE_W-1:0] len_high;
			logic [PHASE_W-1:0] len_low;
			len_high = phase_ticks(high_count, high_unit);
			len_low  = phase_ticks(low_count, low_unit);
			if (want_high && len_high != 0) begin
				in_high   = 1'b1;
				remaining = len_high;
			end else if (!want_high && len_low != 0) begin
				in_high   = 1'b0;
				remaining = len_low;
			end else if (len_high != 0) begin
				in_high   = 1'b1;
				remaining = len_high;
			end else if (len_low != 0) begin
				in_high   = 1'b0;
				remaining = len_low;
			end else begin
				in_high   = 1'b0;
				remaining = '0;
			end
		endfunction

		function bit decode_unit(logic [7:0] c, output unit_t unit);
			unit = UNIT_SEC;
			if (c == CH_SPACE) begin
				unit = UNIT_SEC;
				return 1'b1;
			end
			if (c == CH_M) begin
				unit = UNIT_MSEC;
				return 1'b1;
			end
			if (c == CH_U) begin
				unit = UNIT_USEC;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function logic [COUNT_W-1:0] three_digits(int at);
			return COUNT_W'((chars[at] - CH_ZERO) * 100 + (chars[at + 1] - CH_ZERO) * 10
				+ (chars[at + 2] - CH_ZERO));
		endfunction

		// validate a complete command and start or stop the pulse
		function status_t finish_command();
			int    digit_at [8] = '{0, 1, 2, 5, 6, 7, 10, 11};
			unit_t hu;
			unit_t lu;
			bit    hu_ok;
			bit    lu_ok;
			for (int i = 0; i < 8; i++)
				if (chars[digit_at[i]] < CH_ZERO || chars[digit_at[i]] > CH_NINE) return ST_ERROR;
			if (chars[4] != CH_S || chars[9] != CH_S) return ST_ERROR;
			hu_ok = decode_unit(chars[3], hu);
			lu_ok = decode_unit(chars[8], lu);
			if (!hu_ok || !lu_ok) begin
				running   = 1'b0;
				in_high   = 1'b0;
				remaining = '0;
				return ST_ERROR;
			end
			high_count = three_digits(0);
			low_count  = three_digits(5);
			high_unit  = hu;
			low_unit   = lu;
			running    = 1'b1;
			load_phase(1'b1);
			return ST_ACCEPT;
		endfunction

		// apply one transferred input item and queue the pins it leads to
		function void take_item(logic cmd, logic [7:0] b);
			status_t    st;
			pin_state_t pins;
			st = ST_NONE;
			items++;
			if (cmd) begin
				if (running) begin
					if (remaining > 1) remaining = remaining - 1'b1;
					else load_phase(!in_high);
				end
			end else if (b == CH_CR) begin
				st = ST_NONE;
			end else if (b == CH_G) begin
				st = (wr_pos == CMD_LEN) ? finish_command() : ST_ERROR;
				wr_pos = 0;
			end else if (b == CH_QUERY) begin
				st = ST_ABORT;
				wr_pos = 0;
			end else if (wr_pos >= CMD_LEN) begin
				st = ST_ERROR;
				wr_pos = 0;
			end else begin
				chars[wr_pos] = b;
				wr_pos++;
			end
			case (st)
				ST_ACCEPT: accepted++;
				ST_ERROR:  errors++;
				ST_ABORT:  aborts++;
				default: ;
			endcase
			pins.drive   = running && in_high;
			pins.drive_n = running && !in_high;
			pins.status  = st;
			if (pins.drive != last_drive) toggles++;
			last_drive = pins.drive;
			expected_pins.push_back(pins);
		endfunction

		// compare one transferred result with the oldest expectation
		function void check_pins(logic drive, logic drive_n, logic [1:0] st);
			pin_state_t exp_pins;
			if (expected_pins.size() == 0) begin
				$error("result with no item waiting: drive_out %0b drive_out_n %0b status %0d",
					drive, drive_n, st);
				fails++;
				return;
			end
			exp_pins = expected_pins.pop_front();
			if (drive !== exp_pins.drive) begin
				$error("drive_out: expected %0b, actual %0b", exp_pins.drive, drive);
				fails++;
			end
			if (drive_n !== exp_pins.drive_n) begin
				$error("drive_out_n: expected %0b, actual %0b", exp_pins.drive_n, drive_n);
				fails++;
			end
			if (st !== exp_pins.status) begin
				$error("status: expected %0d, actual %0d", exp_pins.status, st);
				fails++;
			end
		endfunction

		function int pending();
			return expected_pins.size();
		endfunction
	endclass

endpackage

// File: tb/tb_text_command_pulse_generator_core.sv
// testbench top: drives commands and ticks into the pulse generator and checks every result
module tb_text_command_pulse_generator_core import tcpg_pkg::*, tcpg_tb_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SEG_ITEMS    = 260;
	localparam int NUM_SEGS     = 6;
	localparam int DRAIN_CYCLES = 4;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 command     = 1'b0;
	logic [7:0]           rx_byte     = 8'h00;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 drive_out;
	logic                 drive_out_n;
	logic [1:0]           status;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = CFG_TICKS_SEC;
	logic [TICKS_W-1:0]   cfg_data    = '0;

	pulse_scoreboard board;
	int              send_idle_pct  = 13;
	int              recv_stall_pct = 72;
	int              seg_items;
	int              cycles = 0;

	text_command_pulse_generator_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.drive_out  (drive_out),
		.drive_out_n(drive_out_n),
		.status     (status),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// random receiver stalls
	always @(negedge clk) begin
		out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
	end

	// check each result transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_pins(drive_out, drive_out_n, status);
	end

	// one input transfer, entered and left at a falling edge
	task automatic send_item(input logic cmd, input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		board.take_item(cmd, b);
		seg_items++;
		@(negedge clk);
	endtask

	task automatic send_tick();
		send_item(1'b1, 8'($urandom_range(255)));
	endtask

	// hold the sender until every expected result has come
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// write all three tick registers, block idle
	task automatic write_ticks(input logic [TICKS_W-1:0] sec, input logic [TICKS_W-1:0] msec,
		input logic [TICKS_W-1:0] usec);
		logic [CFG_IDX_W-1:0] idx  [3];
		logic [TICKS_W-1:0]   vals [3];
		idx  = '{CFG_TICKS_SEC, CFG_TICKS_MSEC, CFG_TICKS_USEC};
		vals = '{sec, msec, usec};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			board.write_reg(idx[i], vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// any byte that the parser stores
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (b == CH_CR || b == CH_G || b == CH_QUERY);
		return b;
	endfunction

	function automatic logic [7:0] unit_char();
		case ($urandom_range(3))
			0:       return CH_SPACE;
			1:       return CH_M;
			default: return CH_U;
		endcase
	endfunction

	// mostly short phases so the pins keep moving
	function automatic int pick_count();
		return ($urandom_range(9) < 8) ? $urandom_range(0, 6) : $urandom_range(0, 999);
	endfunction

	function automatic void put_count(ref logic [7:0] cmd [CMD_LEN], input int at, input int v);
		cmd[at]     = CH_ZERO + 8'(v / 100);
		cmd[at + 1] = CH_ZERO + 8'((v / 10) % 10);
		cmd[at + 2] = CH_ZERO + 8'(v % 10);
	endfunction

	// one command, mostly well formed, otherwise broken in one way or plain noise
	task automatic send_random_sequence();
		logic [7:0] cmd [CMD_LEN];
		int         digit_at [8] = '{0, 1, 2, 5, 6, 7, 10, 11};
		int         kind;
		int         len;
		int         cr_at;
		bit         overlong;
		logic [7:0] tail;
		logic [7:0] b;
		kind     = $urandom_range(99);
		len      = CMD_LEN;
		cr_at    = -1;
		overlong = 1'b0;
		tail     = CH_G;
		put_count(cmd, 0, pick_count());
		cmd[3] = unit_char();
		cmd[4] = CH_S;
		put_count(cmd, 5, pick_count());
		cmd[8] = unit_char();
		cmd[9] = CH_S;
		cmd[10] = CH_ZERO + 8'($urandom_range(9));
		cmd[11] = CH_ZERO + 8'($urandom_range(9));
		if (kind >= 91) begin
			// raw noise over the full byte range
			repeat ($urandom_range(1, 6)) send_item(1'b0, 8'($urandom_range(255)));
			return;
		end
		if (kind >= 55 && kind < 62) begin
			cr_at = $urandom_range(0, CMD_LEN);
		end else if (kind < 68 && kind >= 62) begin
			// bad unit code stops the output
			do b = plain_byte(); while (b == CH_SPACE || b == CH_M || b == CH_U);
			cmd[($urandom_range(1) != 0) ? 8 : 3] = b;
		end else if (kind < 73 && kind >= 68) begin
			do b = plain_byte(); while (b >= CH_ZERO && b <= CH_NINE);
			cmd[digit_at[$urandom_range(7)]] = b;
		end else if (kind < 77 && kind >= 73) begin
			do b = plain_byte(); while (b == CH_S);
			cmd[($urandom_range(1) != 0) ? 9 : 4] = b;
		end else if (kind < 82 && kind >= 77) begin
			len = $urandom_range(0, CMD_LEN - 1);
		end else if (kind < 86 && kind >= 82) begin
			overlong = 1'b1;
		end else if (kind < 91 && kind >= 86) begin
			len  = $urandom_range(0, CMD_LEN);
			tail = CH_QUERY;
		end
		for (int i = 0; i < len; i++) begin
			if (i == cr_at) send_item(1'b0, CH_CR);
			send_item(1'b0, cmd[i]);
		end
		if (cr_at == CMD_LEN) send_item(1'b0, CH_CR);
		if (overlong) send_item(1'b0, plain_byte());
		send_item(1'b0, tail);
	endtask

	initial begin
		logic [7:0] directed_cmd [CMD_LEN];
		int         tick_run;
		bit         paused;
		board = new();
		paused = 1'b0;
		directed_cmd = '{"0", "0", "2", "u", "s", "0", "0", "3", "u", "s", "9", "9"};

		// hold reset, then release it at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: early end, query, carriage return, idle tick, byte extremes, one command, ticks
		seg_items = 0;
		send_item(1'b0, CH_G);
		send_item(1'b0, CH_QUERY);
		send_item(1'b0, CH_CR);
		send_item(1'b1, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, CH_QUERY);
		for (int i = 0; i < CMD_LEN; i++) send_item(1'b0, directed_cmd[i]);
		send_item(1'b0, CH_G);
		repeat (6) send_tick();

		// random segments, each with its own tick setting; each pair of segments shares an idle mix
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			drain_results();
			case (seg)
				0: write_ticks(24'd1000000, 24'd1000, 24'd1);
				1: write_ticks(24'd1, 24'd1, 24'd1);
				2: write_ticks(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
				3: write_ticks(24'd3, 24'hFFFFFF, 24'd2);
				4: write_ticks(24'($urandom_range(1, 5)), 24'($urandom_range(1, 5)),
					24'($urandom_range(1, 5)));
				default: write_ticks(24'hFFFFFF, 24'd2, 24'd1);
			endcase
			case (seg / 2)
				0: begin
					send_idle_pct  = 13;
					recv_stall_pct = 72;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct = 13;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			seg_items = 0;
			while (seg_items < SEG_ITEMS) begin
				send_random_sequence();
				tick_run = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40);
				repeat (tick_run) send_tick();
				// sender holds off until the output side has caught up
				if (seg == 3 && !paused && seg_items >= SEG_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d items over six tick settings and three sender/receiver idle mixes",
			board.items);
		$display("%0d commands started, %0d errors, %0d queries, %0d drive_out changes",
			board.accepted, board.errors, board.aborts, board.toggles);
		if (board.fails == 0 && board.pending() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
sv/tcpg_pkg.sv
sv/tcpg_cmd_parse.sv
sv/tcpg_pulse.sv
sv/text_command_pulse_generator_core.sv
sv/tcpg_checker.sv
tb/tcpg_tb_pkg.sv
tb/tb_text_command_pulse_generator_core.sv
